@@ hw/rtl/oad_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oad_pkg
// Shared types and constants of the obstacle-avoidance drive controller:
// mode and command codes, register indexes, reset values and the result type.
// ----------------------------------------------------------------------------
package oad_pkg;

    // Field widths.
    localparam int DistW   = 9;
    localparam int SpeedW  = 10;
    localparam int PeriodW = 16;
    localparam int GyroW   = 16;
    localparam int StepW   = 6;
    localparam int CmdW    = 3;
    localparam int HoldW   = 9;
    localparam int ModeW   = 3;
    localparam int CfgIdxW = 3;
    localparam int CfgW    = 16;

    // Mode codes.
    localparam logic [ModeW-1:0] M_STOP     = 3'd0;
    localparam logic [ModeW-1:0] M_START    = 3'd1;
    localparam logic [ModeW-1:0] M_NORMAL   = 3'd2;
    localparam logic [ModeW-1:0] M_SLOW     = 3'd3;
    localparam logic [ModeW-1:0] M_TURN_CW  = 3'd4;
    localparam logic [ModeW-1:0] M_TURN_CCW = 3'd5;
    localparam logic [ModeW-1:0] M_BACKOFF  = 3'd6;

    // Drive command codes.
    localparam logic [CmdW-1:0] CMD_STOP = 3'd0;
    localparam logic [CmdW-1:0] CMD_FWD  = 3'd1;
    localparam logic [CmdW-1:0] CMD_BACK = 3'd2;
    localparam logic [CmdW-1:0] CMD_CW   = 3'd3;
    localparam logic [CmdW-1:0] CMD_CCW  = 3'd4;

    // Hold times in milliseconds.
    localparam logic [HoldW-1:0] HOLD_NONE    = 9'd0;
    localparam logic [HoldW-1:0] HOLD_TURN    = 9'd300;
    localparam logic [HoldW-1:0] HOLD_PAUSE   = 9'd200;
    localparam logic [HoldW-1:0] HOLD_BACKOFF = 9'd500;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] REG_SLOW_DISTANCE = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_TURN_DISTANCE = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_MIN_SPEED     = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_MAX_SPEED     = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_FULL_SPEED    = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_SLOW_SPEED    = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_STALL_PERIOD  = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_SPEED_STEP    = 3'd7;

    // Configuration reset values.
    localparam logic [DistW-1:0]   RST_SLOW_DISTANCE = 9'd40;
    localparam logic [DistW-1:0]   RST_TURN_DISTANCE = 9'd25;
    localparam logic [SpeedW-1:0]  RST_MIN_SPEED     = 10'd700;
    localparam logic [SpeedW-1:0]  RST_MAX_SPEED     = 10'd900;
    localparam logic [SpeedW-1:0]  RST_FULL_SPEED    = 10'd850;
    localparam logic [SpeedW-1:0]  RST_SLOW_SPEED    = 10'd800;
    localparam logic [PeriodW-1:0] RST_STALL_PERIOD  = 16'd8000;
    localparam logic [StepW-1:0]   RST_SPEED_STEP    = 6'd5;

    // One drive command as delivered on the result channel.
    typedef struct packed {
        logic [SpeedW-1:0] speed_left;
        logic [SpeedW-1:0] speed_right;
        logic [CmdW-1:0]   cmd;
        logic [HoldW-1:0]  hold;
        logic              near_left;
        logic              near_right;
        logic              slow;
        logic [ModeW-1:0]  mode;
        logic              last;
    } result_t;

endpackage

@@ hw/rtl/obstacle_avoid_drive_fsm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obstacle_avoid_drive_fsm
// The commands of a tick are written into the result queue on its transfer.
// Throughput: one tick per cycle enters while the four-entry result queue has
// room; the result port moves one command per cycle while out_ready is high,
// and a tick issues one or two commands.
// Reset: asynchronous; mode stop, speeds zero, registers to defaults, queue empty.
// ----------------------------------------------------------------------------
// Obstacle-avoidance drive controller. Each control tick updates the mode,
// the wheel speeds and the indicators in one pass and pushes one or two drive
// commands into a small result queue.
// ----------------------------------------------------------------------------
module obstacle_avoid_drive_fsm (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration write port.
    input  logic                          cfg_we,
    input  logic [oad_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [oad_pkg::CfgW-1:0]      cfg_data,
    // Tick input channel.
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [oad_pkg::DistW-1:0]     dist_left,
    input  logic [oad_pkg::DistW-1:0]     dist_right,
    input  logic [oad_pkg::PeriodW-1:0]   period_left,
    input  logic [oad_pkg::PeriodW-1:0]   period_right,
    input  logic signed [oad_pkg::GyroW-1:0] gyro_z,
    input  logic                          button,
    // Drive command channel.
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [oad_pkg::SpeedW-1:0]    speed_left_out,
    output logic [oad_pkg::SpeedW-1:0]    speed_right_out,
    output logic [oad_pkg::CmdW-1:0]      drive_cmd,
    output logic [oad_pkg::HoldW-1:0]     hold_ms,
    output logic                          led_near_left,
    output logic                          led_near_right,
    output logic                          led_slow,
    output logic [oad_pkg::ModeW-1:0]     mode_out,
    output logic                          last
);

    localparam int SpeedW = oad_pkg::SpeedW;
    localparam int ModeW  = oad_pkg::ModeW;

    // Configuration registers.
    logic [oad_pkg::DistW-1:0]   slow_distance_reg;
    logic [oad_pkg::DistW-1:0]   turn_distance_reg;
    logic [SpeedW-1:0]           min_speed_reg;
    logic [SpeedW-1:0]           max_speed_reg;
    logic [SpeedW-1:0]           full_speed_reg;
    logic [SpeedW-1:0]           slow_speed_reg;
    logic [oad_pkg::PeriodW-1:0] stall_period_reg;
    logic [oad_pkg::StepW-1:0]   speed_step_reg;

    // Controller state.
    logic [ModeW-1:0]  mode_reg, mode_next;
    logic [SpeedW-1:0] left_speed_reg, left_speed_next;
    logic [SpeedW-1:0] right_speed_reg, right_speed_next;
    logic              slow_led_reg, slow_led_next;
    logic              recheck_reg, recheck_next;

    // Result queue.
    oad_pkg::result_t fifo_reg [4];
    logic [1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [2:0]       count_reg;

    // Per-tick combinational signals.
    logic              in_xfer, out_xfer;
    logic [ModeW-1:0]  mode_rc, mode_act;
    logic              near_l, near_r, stalled, gyro_pos;
    logic [SpeedW:0]   step_ext, rs_ext, rs_adj, rs_lo, rs_clamp;
    logic [SpeedW-1:0] rs_corr;
    logic              two_cmds;
    oad_pkg::result_t  res0, res1;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    // Room for two commands after this cycle's pop.
    assign in_ready  = (count_reg <= 3'd2) || ((count_reg == 3'd3) && out_ready);
    assign out_valid = (count_reg != 3'd0);

    // Configuration writes; every three-bit index names one register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slow_distance_reg <= oad_pkg::RST_SLOW_DISTANCE;
            turn_distance_reg <= oad_pkg::RST_TURN_DISTANCE;
            min_speed_reg     <= oad_pkg::RST_MIN_SPEED;
            max_speed_reg     <= oad_pkg::RST_MAX_SPEED;
            full_speed_reg    <= oad_pkg::RST_FULL_SPEED;
            slow_speed_reg    <= oad_pkg::RST_SLOW_SPEED;
            stall_period_reg  <= oad_pkg::RST_STALL_PERIOD;
            speed_step_reg    <= oad_pkg::RST_SPEED_STEP;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                oad_pkg::REG_SLOW_DISTANCE: slow_distance_reg <= cfg_data[8:0];
                oad_pkg::REG_TURN_DISTANCE: turn_distance_reg <= cfg_data[8:0];
                oad_pkg::REG_MIN_SPEED:     min_speed_reg     <= cfg_data[9:0];
                oad_pkg::REG_MAX_SPEED:     max_speed_reg     <= cfg_data[9:0];
                oad_pkg::REG_FULL_SPEED:    full_speed_reg    <= cfg_data[9:0];
                oad_pkg::REG_SLOW_SPEED:    slow_speed_reg    <= cfg_data[9:0];
                oad_pkg::REG_STALL_PERIOD:  stall_period_reg  <= cfg_data[15:0];
                oad_pkg::REG_SPEED_STEP:    speed_step_reg    <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // Post-turn recheck and button, applied before the mode action.
    always_comb
    begin
        mode_rc = mode_reg;
        if (recheck_reg && (dist_left > turn_distance_reg) &&
            (dist_right > turn_distance_reg))
        begin
            mode_rc = oad_pkg::M_START;
        end
        mode_act = mode_rc;
        if (button && (mode_rc == oad_pkg::M_STOP))
        begin
            mode_act = oad_pkg::M_START;
        end
    end

    // Sensor decisions.
    assign near_l   = dist_left < slow_distance_reg;
    assign near_r   = dist_right < slow_distance_reg;
    assign stalled  = (period_left > stall_period_reg) || (period_right > stall_period_reg);
    assign gyro_pos = !gyro_z[oad_pkg::GyroW-1] && (gyro_z != '0);

    // Gyro correction of the right speed; an underflow saturates to the maximum.
    assign step_ext = {{(SpeedW + 1 - oad_pkg::StepW){1'b0}}, speed_step_reg};
    assign rs_ext   = {1'b0, right_speed_reg};
    always_comb
    begin
        rs_adj   = gyro_pos ? (rs_ext + step_ext) : (rs_ext - step_ext);
        rs_lo    = (rs_adj < {1'b0, min_speed_reg}) ? {1'b0, min_speed_reg} : rs_adj;
        rs_clamp = (rs_lo > {1'b0, max_speed_reg}) ? {1'b0, max_speed_reg} : rs_lo;
        if (!gyro_pos && (rs_ext < step_ext))
        begin
            rs_clamp = {1'b0, max_speed_reg};
        end
        rs_corr = rs_clamp[SpeedW-1:0];
    end

    // Mode action: next state and the one or two commands of this tick.
    always_comb
    begin
        mode_next        = mode_act;
        left_speed_next  = left_speed_reg;
        right_speed_next = rs_corr;
        slow_led_next    = slow_led_reg;
        recheck_next     = 1'b0;
        two_cmds         = 1'b0;
        res0             = '0;
        res1             = '0;
        res0.cmd         = oad_pkg::CMD_STOP;
        res0.hold        = oad_pkg::HOLD_NONE;

        unique case (mode_act) inside
            oad_pkg::M_START:
            begin
                left_speed_next  = full_speed_reg;
                right_speed_next = full_speed_reg;
                res0.speed_left  = full_speed_reg;
                res0.speed_right = full_speed_reg;
                res0.cmd         = oad_pkg::CMD_FWD;
                mode_next        = oad_pkg::M_NORMAL;
            end
            oad_pkg::M_NORMAL:
            begin
                if (near_l || near_r)
                begin
                    left_speed_next  = slow_speed_reg;
                    right_speed_next = slow_speed_reg;
                    mode_next        = oad_pkg::M_SLOW;
                end
                if (stalled)
                begin
                    mode_next = oad_pkg::M_BACKOFF;
                end
                res0.speed_left  = left_speed_next;
                res0.speed_right = right_speed_next;
                res0.cmd         = oad_pkg::CMD_FWD;
                slow_led_next    = 1'b0;
            end
            oad_pkg::M_SLOW:
            begin
                // Later checks take priority over earlier ones.
                if ((dist_left > slow_distance_reg) && (dist_right > slow_distance_reg))
                begin
                    mode_next = oad_pkg::M_START;
                end
                if (dist_left < turn_distance_reg)
                begin
                    mode_next = oad_pkg::M_TURN_CW;
                end
                if (dist_right < turn_distance_reg)
                begin
                    mode_next = oad_pkg::M_TURN_CCW;
                end
                if (stalled)
                begin
                    mode_next = oad_pkg::M_BACKOFF;
                end
                res0.speed_left  = left_speed_reg;
                res0.speed_right = rs_corr;
                res0.cmd         = oad_pkg::CMD_FWD;
                slow_led_next    = 1'b1;
            end
            oad_pkg::M_TURN_CW,
            oad_pkg::M_TURN_CCW:
            begin
                res0.speed_left  = full_speed_reg;
                res0.speed_right = full_speed_reg;
                res0.cmd         = (mode_act == oad_pkg::M_TURN_CW) ?
                                   oad_pkg::CMD_CW : oad_pkg::CMD_CCW;
                res0.hold        = oad_pkg::HOLD_TURN;
                res1.cmd         = oad_pkg::CMD_STOP;
                res1.hold        = oad_pkg::HOLD_PAUSE;
                two_cmds         = 1'b1;
                recheck_next     = 1'b1;
            end
            oad_pkg::M_BACKOFF:
            begin
                res0.speed_left  = full_speed_reg;
                res0.speed_right = full_speed_reg;
                res0.cmd         = oad_pkg::CMD_BACK;
                res0.hold        = oad_pkg::HOLD_BACKOFF;
                res1.speed_left  = full_speed_reg;
                res1.speed_right = full_speed_reg;
                res1.cmd         = oad_pkg::CMD_CW;
                res1.hold        = oad_pkg::HOLD_BACKOFF;
                two_cmds         = 1'b1;
                mode_next        = oad_pkg::M_START;
            end
            default:
            begin
                // Stop, and the unused mode code, issue a plain stop command.
            end
        endcase

        // Indicator and mode fields are common to both commands.
        res0.near_left  = near_l;
        res0.near_right = near_r;
        res0.slow       = slow_led_next;
        res0.mode       = mode_next;
        res0.last       = !two_cmds;
        res1.near_left  = near_l;
        res1.near_right = near_r;
        res1.slow       = slow_led_next;
        res1.mode       = mode_next;
        res1.last       = 1'b1;
    end

    // Controller state update on each tick transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= oad_pkg::M_STOP;
            left_speed_reg  <= '0;
            right_speed_reg <= '0;
            slow_led_reg    <= 1'b0;
            recheck_reg     <= 1'b0;
        end
        else if (in_xfer)
        begin
            mode_reg        <= mode_next;
            left_speed_reg  <= left_speed_next;
            right_speed_reg <= right_speed_next;
            slow_led_reg    <= slow_led_next;
            recheck_reg     <= recheck_next;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                wr_ptr_reg <= wr_ptr_reg + (two_cmds ? 2'd2 : 2'd1);
            end
            if (out_xfer)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg
                       + (in_xfer ? (two_cmds ? 3'd2 : 3'd1) : 3'd0)
                       - (out_xfer ? 3'd1 : 3'd0);
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            fifo_reg[wr_ptr_reg] <= res0;
            if (two_cmds)
            begin
                fifo_reg[wr_ptr_reg + 2'd1] <= res1;
            end
        end
    end

    // Head of the queue drives the result channel.
    assign speed_left_out  = fifo_reg[rd_ptr_reg].speed_left;
    assign speed_right_out = fifo_reg[rd_ptr_reg].speed_right;
    assign drive_cmd       = fifo_reg[rd_ptr_reg].cmd;
    assign hold_ms         = fifo_reg[rd_ptr_reg].hold;
    assign led_near_left   = fifo_reg[rd_ptr_reg].near_left;
    assign led_near_right  = fifo_reg[rd_ptr_reg].near_right;
    assign led_slow        = fifo_reg[rd_ptr_reg].slow;
    assign mode_out        = fifo_reg[rd_ptr_reg].mode;
    assign last            = fifo_reg[rd_ptr_reg].last;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the obstacle-avoidance drive controller. A driver
// feeds control ticks from a backlog queue, and a tracker of the drive mode,
// the wheel speeds and the indicators works out the drive commands that each
// transfer must cause. A monitor compares every command with the oldest one
// still owed. Register settings change between phases while the block is idle,
// and both channels idle at random, with one long hold-off on the output.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int SETTLE_CYCLES = 6;
    localparam int IDLE_LIMIT    = 4000;
    localparam int HOLD_AT       = 190;
    localparam int HOLD_CYCLES   = 200;
    localparam int REPORT_MAX    = 10;

    // One control tick as offered on the input channel.
    typedef struct packed {
        logic [oad_pkg::DistW-1:0]        dist_l;
        logic [oad_pkg::DistW-1:0]        dist_r;
        logic [oad_pkg::PeriodW-1:0]      period_l;
        logic [oad_pkg::PeriodW-1:0]      period_r;
        logic signed [oad_pkg::GyroW-1:0] gyro;
        logic                             button;
    } tick_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                        cfg_we    = 1'b0;
    logic [oad_pkg::CfgIdxW-1:0] cfg_index = '0;
    logic [oad_pkg::CfgW-1:0]    cfg_data  = '0;

    logic  in_valid  = 1'b0;
    logic  in_ready;
    tick_t cur_tick  = '0;
    logic  out_valid;
    logic  out_ready = 1'b0;

    logic [oad_pkg::SpeedW-1:0] speed_left_out;
    logic [oad_pkg::SpeedW-1:0] speed_right_out;
    logic [oad_pkg::CmdW-1:0]   drive_cmd;
    logic [oad_pkg::HoldW-1:0]  hold_ms;
    logic                       led_near_left;
    logic                       led_near_right;
    logic                       led_slow;
    logic [oad_pkg::ModeW-1:0]  mode_out;
    logic                       last;

    // Register mirror used by the tracker and the stimulus.
    logic [oad_pkg::DistW-1:0]   cfg_slow_dist  = oad_pkg::RST_SLOW_DISTANCE;
    logic [oad_pkg::DistW-1:0]   cfg_turn_dist  = oad_pkg::RST_TURN_DISTANCE;
    logic [oad_pkg::SpeedW-1:0]  cfg_min_speed  = oad_pkg::RST_MIN_SPEED;
    logic [oad_pkg::SpeedW-1:0]  cfg_max_speed  = oad_pkg::RST_MAX_SPEED;
    logic [oad_pkg::SpeedW-1:0]  cfg_full_speed = oad_pkg::RST_FULL_SPEED;
    logic [oad_pkg::SpeedW-1:0]  cfg_slow_speed = oad_pkg::RST_SLOW_SPEED;
    logic [oad_pkg::PeriodW-1:0] cfg_stall      = oad_pkg::RST_STALL_PERIOD;
    logic [oad_pkg::StepW-1:0]   cfg_step       = oad_pkg::RST_SPEED_STEP;
    logic [oad_pkg::CfgW-1:0]    reg_plan [8];

    // Tracked controller state.
    logic [oad_pkg::ModeW-1:0]  track_mode     = oad_pkg::M_STOP;
    logic [oad_pkg::SpeedW-1:0] track_left     = '0;
    logic [oad_pkg::SpeedW-1:0] track_right    = '0;
    logic                       track_slow_led = 1'b0;
    logic                       track_recheck  = 1'b0;

    tick_t            tick_backlog [$];
    oad_pkg::result_t pending_cmds [$];
    int      ticks_queued = 0;
    int      ticks_sent   = 0;
    int      fail_count   = 0;
    int      tx_wait      = 0;
    int      rx_wait      = 0;
    bit      tx_calm      = 1'b0;
    bit      rx_calm      = 1'b0;
    logic    hold_active  = 1'b0;
    int      hold_count   = 0;
    int      idle_cycles  = 0;

    obstacle_avoid_drive_fsm dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .dist_left       (cur_tick.dist_l),
        .dist_right      (cur_tick.dist_r),
        .period_left     (cur_tick.period_l),
        .period_right    (cur_tick.period_r),
        .gyro_z          (cur_tick.gyro),
        .button          (cur_tick.button),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .speed_left_out  (speed_left_out),
        .speed_right_out (speed_right_out),
        .drive_cmd       (drive_cmd),
        .hold_ms         (hold_ms),
        .led_near_left   (led_near_left),
        .led_near_right  (led_near_right),
        .led_slow        (led_slow),
        .mode_out        (mode_out),
        .last            (last)
    );

    // Clock and reset.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Gap lengths: mostly short, now and then long, none in calm stretches.
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic oad_pkg::result_t make_cmd(input logic [oad_pkg::SpeedW-1:0] sl,
                                                  input logic [oad_pkg::SpeedW-1:0] sr,
                                                  input logic [oad_pkg::CmdW-1:0] cmd,
                                                  input logic [oad_pkg::HoldW-1:0] hold);
        oad_pkg::result_t c;
        c = '0;
        c.speed_left  = sl;
        c.speed_right = sr;
        c.cmd         = cmd;
        c.hold        = hold;
        return c;
    endfunction

    function automatic string fmt_cmd(input oad_pkg::result_t c);
        return $sformatf("L=%0d R=%0d cmd=%0d hold=%0d near=%b%b slow=%b mode=%0d last=%b",
                         c.speed_left, c.speed_right, c.cmd, c.hold, c.near_left,
                         c.near_right, c.slow, c.mode, c.last);
    endfunction

    // Advance the tracked controller by one tick and queue the commands it owes.
    task automatic plan_commands(input tick_t t);
        oad_pkg::result_t cmds [2];
        int      n;
        int      v;
        int      k;
        bit      near_l;
        bit      near_r;
        bit      stalled;
        bit      gyro_up;
        n       = 0;
        stalled = (t.period_l > cfg_stall) || (t.period_r > cfg_stall);
        gyro_up = (t.gyro != '0) && !t.gyro[oad_pkg::GyroW-1];

        // After a turn, this tick's distances decide whether the way is clear.
        if (track_recheck)
        begin
            if (t.dist_l > cfg_turn_dist && t.dist_r > cfg_turn_dist)
                track_mode = oad_pkg::M_START;
            track_recheck = 1'b0;
        end
        if (t.button && track_mode == oad_pkg::M_STOP)
            track_mode = oad_pkg::M_START;
        near_l = t.dist_l < cfg_slow_dist;
        near_r = t.dist_r < cfg_slow_dist;

        // Right wheel trim; stepping down below zero wraps, which clamps to max.
        if (!gyro_up && track_right < cfg_step)
            v = int'(cfg_max_speed);
        else
        begin
            v = gyro_up ? int'(track_right) + int'(cfg_step)
                        : int'(track_right) - int'(cfg_step);
            if (v < int'(cfg_min_speed))
                v = int'(cfg_min_speed);
            if (v > int'(cfg_max_speed))
                v = int'(cfg_max_speed);
        end
        track_right = v[oad_pkg::SpeedW-1:0];

        case (track_mode)
            oad_pkg::M_START:
            begin
                track_left  = cfg_full_speed;
                track_right = cfg_full_speed;
                cmds[0]     = make_cmd(track_left, track_right, oad_pkg::CMD_FWD,
                                       oad_pkg::HOLD_NONE);
                n           = 1;
                track_mode  = oad_pkg::M_NORMAL;
            end
            oad_pkg::M_NORMAL:
            begin
                if (near_l || near_r)
                begin
                    track_left  = cfg_slow_speed;
                    track_right = cfg_slow_speed;
                    track_mode  = oad_pkg::M_SLOW;
                end
                if (stalled)
                    track_mode = oad_pkg::M_BACKOFF;
                cmds[0]        = make_cmd(track_left, track_right, oad_pkg::CMD_FWD,
                                          oad_pkg::HOLD_NONE);
                n              = 1;
                track_slow_led = 1'b0;
            end
            oad_pkg::M_SLOW:
            begin
                // Later checks take priority over earlier ones.
                if (t.dist_l > cfg_slow_dist && t.dist_r > cfg_slow_dist)
                    track_mode = oad_pkg::M_START;
                if (t.dist_l < cfg_turn_dist)
                    track_mode = oad_pkg::M_TURN_CW;
                if (t.dist_r < cfg_turn_dist)
                    track_mode = oad_pkg::M_TURN_CCW;
                if (stalled)
                    track_mode = oad_pkg::M_BACKOFF;
                cmds[0]        = make_cmd(track_left, track_right, oad_pkg::CMD_FWD,
                                          oad_pkg::HOLD_NONE);
                n              = 1;
                track_slow_led = 1'b1;
            end
            oad_pkg::M_TURN_CW, oad_pkg::M_TURN_CCW:
            begin
                cmds[0] = make_cmd(cfg_full_speed, cfg_full_speed,
                                   (track_mode == oad_pkg::M_TURN_CW) ?
                                   oad_pkg::CMD_CW : oad_pkg::CMD_CCW,
                                   oad_pkg::HOLD_TURN);
                cmds[1] = make_cmd('0, '0, oad_pkg::CMD_STOP, oad_pkg::HOLD_PAUSE);
                n       = 2;
                track_recheck = 1'b1;
            end
            oad_pkg::M_BACKOFF:
            begin
                cmds[0]    = make_cmd(cfg_full_speed, cfg_full_speed, oad_pkg::CMD_BACK,
                                      oad_pkg::HOLD_BACKOFF);
                cmds[1]    = make_cmd(cfg_full_speed, cfg_full_speed, oad_pkg::CMD_CW,
                                      oad_pkg::HOLD_BACKOFF);
                n          = 2;
                track_mode = oad_pkg::M_START;
            end
            default:
            begin
                cmds[0] = make_cmd('0, '0, oad_pkg::CMD_STOP, oad_pkg::HOLD_NONE);
                n       = 1;
            end
        endcase

        for (k = 0; k < n; k++)
        begin
            cmds[k].near_left  = near_l;
            cmds[k].near_right = near_r;
            cmds[k].slow       = track_slow_led;
            cmds[k].mode       = track_mode;
            cmds[k].last       = (k == n - 1);
            pending_cmds.push_back(cmds[k]);
        end
    endtask

    // Input driver: one tick per transfer, with random gaps after each.
    always @(posedge clk)
    begin
        tick_t nxt;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                plan_commands(cur_tick);
                ticks_sent = ticks_sent + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (tx_wait != 0)
                begin
                    tx_wait  = tx_wait - 1;
                    in_valid <= 1'b0;
                end
                else if (tick_backlog.size() != 0)
                begin
                    nxt      = tick_backlog.pop_front();
                    cur_tick <= nxt;
                    in_valid <= 1'b1;
                    if ($urandom_range(0, 63) == 0)
                        tx_calm = !tx_calm;
                    tx_wait = pick_gap(tx_calm);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output monitor: checks each transfer and paces out_ready.
    always @(posedge clk)
    begin
        oad_pkg::result_t got;
        oad_pkg::result_t want;
        int      w;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            w = rx_wait;
            if (out_valid && out_ready)
            begin
                got.speed_left  = speed_left_out;
                got.speed_right = speed_right_out;
                got.cmd         = drive_cmd;
                got.hold        = hold_ms;
                got.near_left   = led_near_left;
                got.near_right  = led_near_right;
                got.slow        = led_slow;
                got.mode        = mode_out;
                got.last        = last;
                if (pending_cmds.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    if (fail_count <= REPORT_MAX)
                        $display("[%0t] unexpected drive command: %s", $realtime, fmt_cmd(got));
                end
                else
                begin
                    want = pending_cmds.pop_front();
                    if (got !== want)
                    begin
                        fail_count = fail_count + 1;
                        if (fail_count <= REPORT_MAX)
                            $display("[%0t] drive command mismatch\n  expected %s\n  actual   %s",
                                     $realtime, fmt_cmd(want), fmt_cmd(got));
                    end
                end
                if ($urandom_range(0, 63) == 0)
                    rx_calm = !rx_calm;
                w = pick_gap(rx_calm);
            end
            if (hold_active)
                out_ready <= 1'b0;
            else if (w != 0)
            begin
                out_ready <= 1'b0;
                w = w - 1;
            end
            else
                out_ready <= 1'b1;
            rx_wait = w;
        end
    end

    // One long hold-off on the output so the result queue fills and in_ready drops.
    always @(posedge clk)
    begin
        if (rst_n && ticks_sent >= HOLD_AT && hold_count < HOLD_CYCLES)
        begin
            hold_count  = hold_count + 1;
            hold_active <= (hold_count < HOLD_CYCLES);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout after %0d cycles without a transfer", IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic add_tick(input logic [oad_pkg::DistW-1:0] dl,
                            input logic [oad_pkg::DistW-1:0] dr,
                            input logic [oad_pkg::PeriodW-1:0] pl,
                            input logic [oad_pkg::PeriodW-1:0] pr,
                            input logic signed [oad_pkg::GyroW-1:0] g, input logic b);
        tick_t t;
        t.dist_l   = dl;
        t.dist_r   = dr;
        t.period_l = pl;
        t.period_r = pr;
        t.gyro     = g;
        t.button   = b;
        tick_backlog.push_back(t);
        ticks_queued = ticks_queued + 1;
    endtask

    // Distances cluster around both thresholds so every mode change is reached.
    function automatic logic [oad_pkg::DistW-1:0] pick_dist();
        int r;
        int d;
        r = $urandom_range(0, 9);
        if (r < 3)
            d = $urandom_range(0, 511);
        else if (r < 5)
            d = int'(cfg_slow_dist) + int'($urandom_range(0, 4)) - 2;
        else if (r < 7)
            d = int'(cfg_turn_dist) + int'($urandom_range(0, 4)) - 2;
        else if (r == 7)
            d = $urandom_range(0, 1) ? 511 : 0;
        else if (cfg_turn_dist < cfg_slow_dist)
            d = $urandom_range(cfg_turn_dist, cfg_slow_dist);
        else
            d = $urandom_range(0, 511);
        if (d < 0)
            d = 0;
        if (d > 511)
            d = 511;
        return d[oad_pkg::DistW-1:0];
    endfunction

    // Mostly a turning wheel, sometimes right at or past the stall limit.
    function automatic logic [oad_pkg::PeriodW-1:0] pick_period();
        int r;
        int p;
        r = $urandom_range(0, 19);
        if (r < 17)
            p = $urandom_range(0, cfg_stall);
        else if (r == 17)
            p = int'(cfg_stall) + int'($urandom_range(0, 1));
        else
            p = $urandom_range(0, 65535);
        if (p > 65535)
            p = 65535;
        return p[oad_pkg::PeriodW-1:0];
    endfunction

    function automatic logic signed [oad_pkg::GyroW-1:0] pick_gyro();
        int r;
        r = $urandom_range(0, 15);
        case (r)
            0, 1: return '0;
            2:    return 16'sh8000;
            3:    return 16'sh7FFF;
            4:    return 16'sd1;
            5:    return -16'sd1;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic add_random_ticks(input int count);
        int i;
        for (i = 0; i < count; i++)
            add_tick(pick_dist(), pick_dist(), pick_period(), pick_period(), pick_gyro(),
                     ($urandom_range(0, 3) == 0));
    endtask

    // Wait until every tick has moved and every command has arrived.
    task automatic wait_idle();
        @(posedge clk);
        while (ticks_sent != ticks_queued || pending_cmds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all eight registers from reg_plan and update the mirror.
    task automatic apply_regs();
        int                          i;
        logic [oad_pkg::CfgIdxW-1:0] idx;
        for (i = 0; i < 8; i++)
        begin
            idx = i[oad_pkg::CfgIdxW-1:0];
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= reg_plan[i];
            case (idx)
                oad_pkg::REG_SLOW_DISTANCE:
                    cfg_slow_dist  = reg_plan[i][oad_pkg::DistW-1:0];
                oad_pkg::REG_TURN_DISTANCE:
                    cfg_turn_dist  = reg_plan[i][oad_pkg::DistW-1:0];
                oad_pkg::REG_MIN_SPEED:
                    cfg_min_speed  = reg_plan[i][oad_pkg::SpeedW-1:0];
                oad_pkg::REG_MAX_SPEED:
                    cfg_max_speed  = reg_plan[i][oad_pkg::SpeedW-1:0];
                oad_pkg::REG_FULL_SPEED:
                    cfg_full_speed = reg_plan[i][oad_pkg::SpeedW-1:0];
                oad_pkg::REG_SLOW_SPEED:
                    cfg_slow_speed = reg_plan[i][oad_pkg::SpeedW-1:0];
                oad_pkg::REG_STALL_PERIOD:
                    cfg_stall      = reg_plan[i][oad_pkg::PeriodW-1:0];
                oad_pkg::REG_SPEED_STEP:
                    cfg_step       = reg_plan[i][oad_pkg::StepW-1:0];
                default: ;
            endcase
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_plan(input int phase);
        int lo;
        int i;
        case (phase)
            // Every register at its top value, but the minimum speed at zero.
            1:
            begin
                reg_plan[oad_pkg::REG_SLOW_DISTANCE] = 511;
                reg_plan[oad_pkg::REG_TURN_DISTANCE] = 511;
                reg_plan[oad_pkg::REG_MIN_SPEED]     = 0;
                reg_plan[oad_pkg::REG_MAX_SPEED]     = 1023;
                reg_plan[oad_pkg::REG_FULL_SPEED]    = 1023;
                reg_plan[oad_pkg::REG_SLOW_SPEED]    = 1023;
                reg_plan[oad_pkg::REG_STALL_PERIOD]  = 65535;
                reg_plan[oad_pkg::REG_SPEED_STEP]    = 63;
            end
            // Bottom values, with the speed clamps inverted.
            2:
            begin
                reg_plan[oad_pkg::REG_SLOW_DISTANCE] = 0;
                reg_plan[oad_pkg::REG_TURN_DISTANCE] = 0;
                reg_plan[oad_pkg::REG_MIN_SPEED]     = 1023;
                reg_plan[oad_pkg::REG_MAX_SPEED]     = 0;
                reg_plan[oad_pkg::REG_FULL_SPEED]    = 0;
                reg_plan[oad_pkg::REG_SLOW_SPEED]    = 0;
                reg_plan[oad_pkg::REG_STALL_PERIOD]  = 0;
                reg_plan[oad_pkg::REG_SPEED_STEP]    = 0;
            end
            // Low wheel speeds with a big step, so the right speed wraps often.
            3:
            begin
                reg_plan[oad_pkg::REG_SLOW_DISTANCE] = 16'(oad_pkg::RST_SLOW_DISTANCE);
                reg_plan[oad_pkg::REG_TURN_DISTANCE] = 16'(oad_pkg::RST_TURN_DISTANCE);
                reg_plan[oad_pkg::REG_MIN_SPEED]     = 0;
                reg_plan[oad_pkg::REG_MAX_SPEED]     = 1023;
                reg_plan[oad_pkg::REG_FULL_SPEED]    = 3;
                reg_plan[oad_pkg::REG_SLOW_SPEED]    = 1;
                reg_plan[oad_pkg::REG_STALL_PERIOD]  = oad_pkg::RST_STALL_PERIOD;
                reg_plan[oad_pkg::REG_SPEED_STEP]    = 63;
            end
            // Full-width write data; the unused upper bits must be dropped.
            4:
            begin
                for (i = 0; i < 8; i++)
                    reg_plan[i] = 16'($urandom_range(0, 65535));
            end
            // Back to the reset values, written explicitly.
            7:
            begin
                reg_plan[oad_pkg::REG_SLOW_DISTANCE] = 16'(oad_pkg::RST_SLOW_DISTANCE);
                reg_plan[oad_pkg::REG_TURN_DISTANCE] = 16'(oad_pkg::RST_TURN_DISTANCE);
                reg_plan[oad_pkg::REG_MIN_SPEED]     = 16'(oad_pkg::RST_MIN_SPEED);
                reg_plan[oad_pkg::REG_MAX_SPEED]     = 16'(oad_pkg::RST_MAX_SPEED);
                reg_plan[oad_pkg::REG_FULL_SPEED]    = 16'(oad_pkg::RST_FULL_SPEED);
                reg_plan[oad_pkg::REG_SLOW_SPEED]    = 16'(oad_pkg::RST_SLOW_SPEED);
                reg_plan[oad_pkg::REG_STALL_PERIOD]  = oad_pkg::RST_STALL_PERIOD;
                reg_plan[oad_pkg::REG_SPEED_STEP]    = 16'(oad_pkg::RST_SPEED_STEP);
            end
            // Plausible random settings.
            default:
            begin
                reg_plan[oad_pkg::REG_SLOW_DISTANCE] = 16'($urandom_range(10, 300));
                reg_plan[oad_pkg::REG_TURN_DISTANCE] =
                    16'($urandom_range(0, reg_plan[oad_pkg::REG_SLOW_DISTANCE]));
                lo                                   = $urandom_range(0, 900);
                reg_plan[oad_pkg::REG_MIN_SPEED]     = 16'(lo);
                reg_plan[oad_pkg::REG_MAX_SPEED]     = 16'($urandom_range(lo, 1023));
                reg_plan[oad_pkg::REG_FULL_SPEED]    = 16'($urandom_range(0, 1023));
                reg_plan[oad_pkg::REG_SLOW_SPEED]    = 16'($urandom_range(0, 1023));
                reg_plan[oad_pkg::REG_STALL_PERIOD]  = 16'($urandom_range(0, 65535));
                reg_plan[oad_pkg::REG_SPEED_STEP]    = 16'($urandom_range(0, 63));
            end
        endcase
    endtask

    // Stimulus sequence and final verdict.
    initial
    begin
        int phase;
        wait (rst_n);
        @(posedge clk);

        // Directed walk through every mode, at reset register values.
        add_tick(511, 511, 0, 0, 16'sd0, 1'b0);          // stop; right speed wraps to max
        add_tick(0, 0, 65535, 65535, 16'sh8000, 1'b0);   // stop, extreme fields
        add_tick(511, 511, 0, 0, 16'sh7FFF, 1'b1);       // button starts the robot
        add_tick(511, 511, 100, 100, 16'sd1, 1'b0);      // normal cruise
        add_tick(39, 511, 100, 100, -16'sd1, 1'b0);      // left near: slow down
        add_tick(40, 40, 8000, 8000, 16'sd0, 1'b0);      // on the thresholds: stay slow
        add_tick(24, 100, 100, 100, 16'sd5, 1'b1);       // turn clockwise, button ignored
        add_tick(0, 0, 0, 0, 16'sd0, 1'b0);              // turn plus pause
        add_tick(25, 511, 0, 0, 16'sd0, 1'b0);           // recheck blocked: turn again
        add_tick(26, 26, 0, 0, 16'sd0, 1'b0);            // recheck clear: start
        add_tick(511, 0, 0, 0, 16'sd0, 1'b0);            // right near: slow down
        add_tick(24, 24, 0, 0, 16'sd0, 1'b0);            // both close: anticlockwise wins
        add_tick(511, 511, 0, 0, 16'sd0, 1'b0);          // anticlockwise turn
        add_tick(511, 511, 0, 0, 16'sd0, 1'b0);          // recheck clear: start
        add_tick(511, 511, 8001, 0, 16'sd0, 1'b0);       // left wheel stalled: back off
        add_tick(511, 511, 0, 0, 16'sd0, 1'b1);          // back off commands
        add_tick(511, 511, 0, 0, 16'sd0, 1'b1);          // start, button ignored
        add_tick(0, 0, 0, 65535, 16'sd0, 1'b0);          // near and stalled: back off wins
        add_tick(100, 100, 0, 0, 16'sd0, 1'b0);          // back off commands
        add_tick(100, 100, 0, 0, 16'sd0, 1'b0);          // start
        add_tick(30, 100, 0, 0, 16'sd0, 1'b0);           // slow down
        add_tick(41, 41, 0, 0, 16'sd0, 1'b0);            // way clear: start
        add_tick(0, 0, 0, 0, 16'sd0, 1'b0);              // start ignores distance
        add_tick(10, 10, 0, 0, 16'sd0, 1'b0);            // slow down
        add_tick(0, 511, 0, 9000, 16'sd0, 1'b0);         // turn overridden by stall
        add_random_ticks(150);
        wait_idle();

        for (phase = 1; phase <= 7; phase++)
        begin
            set_plan(phase);
            apply_regs();
            add_random_ticks((phase <= 3) ? 60 : (phase == 4) ? 80 : 150);
            wait_idle();
        end

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ obstacle_avoid_drive_fsm.f @@
hw/rtl/oad_pkg.sv
hw/rtl/obstacle_avoid_drive_fsm.sv
tb/tb_top.sv
